[hw/rtl/fte_pkg.sv]
// Shared types and constants for the IPv4 five-tuple extractor.
package fte_pkg;

    // Width of the saturating byte counter.
    localparam int LENGTH_BITS = 16;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    localparam int ETH_HDR_LEN    = 14;
    localparam int IPV4_MIN_WORDS = 5;
    localparam int WORD_BYTES     = 4;
    localparam int TCP_HDR_LEN    = 20;
    localparam int UDP_HDR_LEN    = 8;
    localparam int PORT_BYTES     = 4;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Byte positions within the frame.
    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_IHL      = ETH_HDR_LEN;
    localparam int POS_PROTO    = ETH_HDR_LEN + 9;
    localparam int POS_SRC_LO   = ETH_HDR_LEN + 12;
    localparam int POS_DST_LO   = ETH_HDR_LEN + 16;
    localparam int POS_DST_END  = ETH_HDR_LEN + 20;

    // Shortest frame that can carry a valid tuple (UDP, no options).
    localparam int MIN_VALID_LEN = ETH_HDR_LEN + IPV4_MIN_WORDS * WORD_BYTES + UDP_HDR_LEN;

    typedef enum logic [1:0] {
        VERDICT_SHORT     = 2'd0,
        VERDICT_NOT_IPV4  = 2'd1,
        VERDICT_MALFORMED = 2'd2,
        VERDICT_VALID     = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } t_in_beat;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] frame_length;
    } t_out_beat;

endpackage

[hw/rtl/fte_capture.sv]
// Frame state, header field capture by byte position, and verdict logic.
module fte_capture
    import fte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_beat  i_beat,
    output t_out_beat o_result
);

    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [15:0]            r_ether, n_ether;
    logic [3:0]             r_hw, n_hw;
    logic [7:0]             r_proto, n_proto;
    logic [31:0]            r_src, n_src;
    logic [31:0]            r_dst, n_dst;
    logic [31:0]            r_ports, n_ports;

    logic [6:0]             cur_tstart;
    logic [6:0]             fin_tstart;
    logic [LENGTH_BITS-1:0] len;
    logic [31:0]            len_ext;
    logic                   ok;
    t_verdict               verdict;

    // Transport header start for the header length currently held.
    assign cur_tstart = 7'(ETH_HDR_LEN) + {1'b0, r_hw, 2'b00};

    always_comb begin
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        n_ether = r_ether;
        n_hw    = r_hw;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_ports = r_ports;
        if (r_count == LENGTH_BITS'(POS_ETYPE_HI) || r_count == LENGTH_BITS'(POS_ETYPE_LO)) begin
            n_ether = {r_ether[7:0], i_beat.frame_byte};
        end
        if (r_count == LENGTH_BITS'(POS_IHL)) begin
            n_hw = i_beat.frame_byte[3:0];
        end
        if (r_count == LENGTH_BITS'(POS_PROTO)) begin
            n_proto = i_beat.frame_byte;
        end
        if (r_count >= LENGTH_BITS'(POS_SRC_LO) && r_count < LENGTH_BITS'(POS_DST_LO)) begin
            n_src = {r_src[23:0], i_beat.frame_byte};
        end
        if (r_count >= LENGTH_BITS'(POS_DST_LO) && r_count < LENGTH_BITS'(POS_DST_END)) begin
            n_dst = {r_dst[23:0], i_beat.frame_byte};
        end
        // Ports are the first four bytes after the IPv4 header, options included.
        if (r_hw >= 4'(IPV4_MIN_WORDS) && r_count >= LENGTH_BITS'(cur_tstart)
                && r_count < LENGTH_BITS'(cur_tstart + 7'(PORT_BYTES))) begin
            n_ports = {r_ports[23:0], i_beat.frame_byte};
        end
    end

    // The verdict sees the state with the current byte already taken in.
    assign len        = n_count;
    assign len_ext    = 32'(len);
    assign fin_tstart = 7'(ETH_HDR_LEN) + {1'b0, n_hw, 2'b00};

    always_comb begin
        if (len < LENGTH_BITS'(ETH_HDR_LEN)) begin
            verdict = VERDICT_SHORT;
        end else if (n_ether != ETHERTYPE_IPV4) begin
            verdict = VERDICT_NOT_IPV4;
        end else if (len < LENGTH_BITS'(ETH_HDR_LEN + IPV4_MIN_WORDS * WORD_BYTES)
                || n_hw < 4'(IPV4_MIN_WORDS) || len < LENGTH_BITS'(fin_tstart)) begin
            verdict = VERDICT_MALFORMED;
        end else if (n_proto == PROTO_TCP) begin
            verdict = (len >= LENGTH_BITS'(fin_tstart + 7'(TCP_HDR_LEN)))
                    ? VERDICT_VALID : VERDICT_MALFORMED;
        end else if (n_proto == PROTO_UDP) begin
            verdict = (len >= LENGTH_BITS'(fin_tstart + 7'(UDP_HDR_LEN)))
                    ? VERDICT_VALID : VERDICT_MALFORMED;
        end else begin
            verdict = VERDICT_MALFORMED;
        end
    end

    assign ok = (verdict == VERDICT_VALID);

    always_comb begin
        o_result.verdict             = verdict;
        o_result.source_address      = ok ? n_src : 32'd0;
        o_result.destination_address = ok ? n_dst : 32'd0;
        o_result.protocol_number     = ok ? n_proto : 8'd0;
        o_result.source_port         = ok ? n_ports[31:16] : 16'd0;
        o_result.destination_port    = ok ? n_ports[15:0] : 16'd0;
        o_result.frame_length        = (len_ext > 32'h0000_FFFF) ? 16'hFFFF : len_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.end_of_frame)) begin
            r_count <= '0;
            r_ether <= '0;
            r_hw    <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_ports <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_ether <= n_ether;
            r_hw    <= n_hw;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_ports <= n_ports;
        end
    end

endmodule

[hw/rtl/ipv4_five_tuple_extractor.sv]
// Top level: input register, frame capture, and the result register.
// A result is registered when its end-of-frame beat leaves the input register.
// Throughput: one byte beat per cycle; the input register drains into the frame state
// every cycle, and only stalls on an end-of-frame beat while the result register is full
// and is not being read in the same cycle.
// Reset: synchronous, active low; clears both valid flags and all frame state.
module ipv4_five_tuple_extractor
    import fte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    logic      r_in_valid, n_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out_beat;
    t_out_beat result;
    logic      advance;
    logic      load;

    // A plain byte always moves on; a closing byte needs room in the result register.
    assign advance = r_in_valid && (!r_in_beat.end_of_frame || !r_out_valid || i_out_ready);
    assign load    = advance && r_in_beat.end_of_frame;

    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

    fte_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_beat   (r_in_beat),
        .o_result (result)
    );

    always_comb begin
        n_in_valid  = o_in_ready ? i_in_valid : r_in_valid;
        n_out_valid = load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_data;
        end
        if (load) begin
            r_out_beat <= result;
        end
    end

    // A byte that does not close a frame never produces a result.
    a_no_result_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_beat.end_of_frame && (!r_out_valid || i_out_ready))
        |=> !r_out_valid)
        else $error("result appeared without an end-of-frame beat");

    // A held result must not be overwritten by the next frame.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_beat))
        else $error("pending result overwritten");

    // A valid tuple needs at least Ethernet, a bare IPv4 header and a UDP header.
    a_valid_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.verdict == VERDICT_VALID)
        |-> (r_out_beat.frame_length >= 16'(MIN_VALID_LEN)))
        else $error("valid verdict on a frame too short to carry a tuple");

    // Tuple fields are zero whenever the verdict is not valid.
    a_tuple_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.verdict != VERDICT_VALID)
        |-> (r_out_beat.source_address == 32'd0 && r_out_beat.destination_address == 32'd0
             && r_out_beat.protocol_number == 8'd0 && r_out_beat.source_port == 16'd0
             && r_out_beat.destination_port == 16'd0))
        else $error("tuple fields not cleared on a rejected frame");

endmodule
